@@ rtl/rqrs_pkg.sv @@
// shared constants, request and status codes, pointer helpers for the record queue
package rqrs_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int KEY_BITS     = 32;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int REC_W        = KEY_BITS + PAYLOAD_BITS;

    // request codes
    localparam logic [2:0] REQ_ENQ      = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD = 3'd1;
    localparam logic [2:0] REQ_DEQ      = 3'd2;
    localparam logic [2:0] REQ_PEEK     = 3'd3;
    localparam logic [2:0] REQ_REV      = 3'd4;
    localparam logic [2:0] REQ_SORT     = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // circular add, both operands below DEPTH
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W + 1)'(DEPTH)) begin
            s = s - (PTR_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0) begin
            r = PTR_W'(DEPTH - 1);
        end else begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/rqrs_req_if.sv @@
// request channel: valid/ready handshake with request type, key and payload
interface rqrs_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  req_type;
    logic signed [31:0] key;
    logic        [63:0] payload;

    modport source (output valid, output req_type, output key, output payload, input ready);
    modport sink   (input valid, input req_type, input key, input payload, output ready);
endinterface

@@ rtl/rqrs_rsp_if.sv @@
// response channel: valid/ready handshake with status, count and head entry
interface rqrs_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic        [4:0]  entry_count;
    logic               head_valid;
    logic signed [31:0] head_key;
    logic        [63:0] head_payload;

    modport source (output valid, output status, output entry_count, output head_valid,
                    output head_key, output head_payload, input ready);
    modport sink   (input valid, input status, input entry_count, input head_valid,
                    input head_key, input head_payload, output ready);
endinterface

@@ rtl/rqrs_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
module rqrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/record_queue_with_reverse_and_sort_core.sv @@
// top level of the bounded double-ended record queue with reverse and sort
//
// Bounded double-ended queue of records (signed 32-bit key plus payload) held in one
// record memory with a registered read port. A request is taken only while the block
// is idle; every request gives exactly one response with status, entry count and the
// head record after the operation. Enqueue, head insert, dequeue, peek and reverse pass
// through the update at acceptance, the head read and the response register, and take the
// next request once back in idle; the block accepts the next request while an earlier
// response still waits in the output register. Reverse only flips a direction flag. Sort
// runs on the single memory read port: with n entries a reversed queue is first put back
// in normal order one swapped pair at a time (read low, read high, write low, write high),
// then a stable bubble sort runs passes until a pass makes no swap (at most n passes),
// then the head is read and the response is issued. The memory needs no clearing pass
// after reset: only entries inside the held range are ever used.
module record_queue_with_reverse_and_sort_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rqrs_req_if.sink          i_req,
    rqrs_rsp_if.source        o_rsp
);

    localparam int PTR_W = rqrs_pkg::PTR_W;
    localparam int CNT_W = rqrs_pkg::CNT_W;
    localparam int REC_W = rqrs_pkg::REC_W;
    localparam int KEY_BITS = rqrs_pkg::KEY_BITS;
    localparam int PAYLOAD_BITS = rqrs_pkg::PAYLOAD_BITS;

    typedef enum logic [11:0] {
        S_IDLE       = 12'b0000_0000_0001,
        S_HEAD       = 12'b0000_0000_0010,
        S_DONE       = 12'b0000_0000_0100,
        S_REV_RD_LO  = 12'b0000_0000_1000,
        S_REV_RD_HI  = 12'b0000_0001_0000,
        S_REV_WR_LO  = 12'b0000_0010_0000,
        S_REV_WR_HI  = 12'b0000_0100_0000,
        S_SORT_LOAD  = 12'b0000_1000_0000,
        S_SORT_FIRST = 12'b0001_0000_0000,
        S_SORT_RD    = 12'b0010_0000_0000,
        S_SORT_CMP   = 12'b0100_0000_0000,
        S_SORT_LAST  = 12'b1000_0000_0000
    } t_state;

    // control state
    t_state            r_state,   n_state;
    logic [PTR_W-1:0]  r_head,    n_head;
    logic [PTR_W-1:0]  r_tail,    n_tail;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic              r_rev,     n_rev;
    logic [1:0]        r_status,  n_status;
    logic              r_swapped, n_swapped;
    logic [PTR_W-1:0]  r_idx,     n_idx;
    logic [PTR_W-1:0]  r_hi,      n_hi;
    // record carried through the swap and bubble passes
    logic [REC_W-1:0]  r_hold,    n_hold;

    // response register
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [4:0]              r_out_count;
    logic                    r_out_hvalid;
    logic signed [KEY_BITS-1:0] r_out_key;
    logic [63:0]             r_out_payload;

    // memory port
    logic              w_we;
    logic [PTR_W-1:0]  w_waddr;
    logic [REC_W-1:0]  w_wdata;
    logic              w_re;
    logic [PTR_W-1:0]  w_raddr;
    logic [REC_W-1:0]  w_rdata;

    logic              w_acc;
    logic              w_full;
    logic              w_empty;
    logic              w_at_back;
    logic              w_gt;
    logic              w_load;
    logic [PTR_W-1:0]  w_last;
    logic [REC_W-1:0]  w_in_rec;

    rqrs_ram #(
        .WIDTH (REC_W),
        .DEPTH (rqrs_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && (r_state == S_IDLE);
    assign w_full      = (r_count == CNT_W'(rqrs_pkg::DEPTH));
    assign w_empty     = (r_count == '0);
    // logical tail is the physical back unless the order is flipped
    assign w_at_back   = (i_req.req_type == rqrs_pkg::REQ_ENQ) != r_rev;
    assign w_last      = PTR_W'(r_count - CNT_W'(1));
    assign w_in_rec    = {i_req.key, i_req.payload[PAYLOAD_BITS-1:0]};
    // strict greater-than keeps equal keys in order
    assign w_gt        = $signed(r_hold[REC_W-1 -: KEY_BITS])
                         > $signed(w_rdata[REC_W-1 -: KEY_BITS]);
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_rev     = r_rev;
        n_status  = r_status;
        n_swapped = r_swapped;
        n_idx     = r_idx;
        n_hi      = r_hi;
        n_hold    = r_hold;
        w_we      = 1'b0;
        w_waddr   = r_tail;
        w_wdata   = w_in_rec;
        w_re      = 1'b0;
        w_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_status = rqrs_pkg::ST_OK;
                    n_state  = S_HEAD;
                    case (i_req.req_type)
                        rqrs_pkg::REQ_ENQ, rqrs_pkg::REQ_INS_HEAD: begin
                            if (w_full) begin
                                n_status = rqrs_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (w_at_back) begin
                                    w_waddr = r_tail;
                                    n_tail  = rqrs_pkg::ptr_add(r_tail, PTR_W'(1));
                                end else begin
                                    w_waddr = rqrs_pkg::ptr_dec(r_head);
                                    n_head  = rqrs_pkg::ptr_dec(r_head);
                                end
                            end
                        end
                        rqrs_pkg::REQ_DEQ: begin
                            if (w_empty) begin
                                n_status = rqrs_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (!r_rev) begin
                                    n_head = rqrs_pkg::ptr_add(r_head, PTR_W'(1));
                                end else begin
                                    n_tail = rqrs_pkg::ptr_dec(r_tail);
                                end
                            end
                        end
                        rqrs_pkg::REQ_PEEK: begin
                            if (w_empty) begin
                                n_status = rqrs_pkg::ST_EMPTY;
                            end
                        end
                        rqrs_pkg::REQ_REV: begin
                            if (w_empty) begin
                                n_status = rqrs_pkg::ST_EMPTY;
                            end else begin
                                n_rev = !r_rev;
                            end
                        end
                        rqrs_pkg::REQ_SORT: begin
                            if (w_empty) begin
                                n_status = rqrs_pkg::ST_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                n_rev = 1'b0;
                            end else if (r_rev) begin
                                // restore normal physical order before sorting
                                n_idx   = '0;
                                n_hi    = w_last;
                                n_state = S_REV_RD_LO;
                            end else begin
                                n_state = S_SORT_LOAD;
                            end
                        end
                        default: begin
                            // unused codes leave the queue alone
                        end
                    endcase
                end
            end

            S_HEAD: begin
                w_re    = 1'b1;
                w_raddr = r_rev ? rqrs_pkg::ptr_dec(r_tail) : r_head;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end

            S_REV_RD_LO: begin
                w_re    = 1'b1;
                w_raddr = rqrs_pkg::ptr_add(r_head, r_idx);
                n_state = S_REV_RD_HI;
            end

            S_REV_RD_HI: begin
                n_hold  = w_rdata;
                w_re    = 1'b1;
                w_raddr = rqrs_pkg::ptr_add(r_head, r_hi);
                n_state = S_REV_WR_LO;
            end

            S_REV_WR_LO: begin
                w_we    = 1'b1;
                w_waddr = rqrs_pkg::ptr_add(r_head, r_idx);
                w_wdata = w_rdata;
                n_state = S_REV_WR_HI;
            end

            S_REV_WR_HI: begin
                w_we    = 1'b1;
                w_waddr = rqrs_pkg::ptr_add(r_head, r_hi);
                w_wdata = r_hold;
                n_idx   = r_idx + PTR_W'(1);
                n_hi    = r_hi - PTR_W'(1);
                if ((r_idx + PTR_W'(1)) < (r_hi - PTR_W'(1))) begin
                    n_state = S_REV_RD_LO;
                end else begin
                    n_rev   = 1'b0;
                    n_state = S_SORT_LOAD;
                end
            end

            S_SORT_LOAD: begin
                w_re      = 1'b1;
                w_raddr   = r_head;
                n_swapped = 1'b0;
                n_state   = S_SORT_FIRST;
            end

            S_SORT_FIRST: begin
                n_hold  = w_rdata;
                n_idx   = PTR_W'(1);
                n_state = S_SORT_RD;
            end

            S_SORT_RD: begin
                w_re    = 1'b1;
                w_raddr = rqrs_pkg::ptr_add(r_head, r_idx);
                n_state = S_SORT_CMP;
            end

            S_SORT_CMP: begin
                // smaller of the pair settles one place back, larger bubbles on
                w_we    = 1'b1;
                w_waddr = rqrs_pkg::ptr_add(r_head, r_idx - PTR_W'(1));
                if (w_gt) begin
                    w_wdata   = w_rdata;
                    n_swapped = 1'b1;
                end else begin
                    w_wdata = r_hold;
                    n_hold  = w_rdata;
                end
                if (r_idx == w_last) begin
                    n_state = S_SORT_LAST;
                end else begin
                    n_idx   = r_idx + PTR_W'(1);
                    n_state = S_SORT_RD;
                end
            end

            S_SORT_LAST: begin
                w_we    = 1'b1;
                w_waddr = rqrs_pkg::ptr_add(r_head, w_last);
                w_wdata = r_hold;
                n_rev   = 1'b0;
                n_state = r_swapped ? S_SORT_LOAD : S_HEAD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_status    <= rqrs_pkg::ST_OK;
            r_swapped   <= 1'b0;
            r_idx       <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_rev     <= n_rev;
            r_status  <= n_status;
            r_swapped <= n_swapped;
            r_idx     <= n_idx;
            r_hi      <= n_hi;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_count  <= 5'(r_count);
            r_out_hvalid <= !w_empty;
            if (w_empty) begin
                r_out_key     <= '0;
                r_out_payload <= '0;
            end else begin
                r_out_key     <= $signed(w_rdata[REC_W-1 -: KEY_BITS]);
                r_out_payload <= 64'(w_rdata[PAYLOAD_BITS-1:0]);
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = r_out_count;
    assign o_rsp.head_valid   = r_out_hvalid;
    assign o_rsp.head_key     = r_out_key;
    assign o_rsp.head_payload = r_out_payload;

`ifndef SYNTHESIS
    // pointers and count stay consistent around the ring
    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(rqrs_pkg::DEPTH))
            |-> (rqrs_pkg::ptr_add(r_head, PTR_W'(r_count)) == r_tail))
        else $error("head, tail and count out of step");

    // count and head only move on an accepted transaction
    a_busy_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> ($stable(r_count) && $stable(r_head)))
        else $error("queue pointers moved while busy");

    // the bubble pass only runs with at least two entries
    a_sort_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT_CMP) |-> (r_count >= CNT_W'(2)))
        else $error("sort compare with fewer than two entries");

    // a response only appears from the result state
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("response raised outside result state");
`endif

endmodule
